@@ rtl/core/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and the CORDIC arctangent table for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = 5;
    localparam int DIV_NUM_W    = 58;
    localparam int DIV_DEN_W    = 24;
    localparam int DIV_CNT_W    = 6;
    localparam int NUM_LANES    = 4;

    // divider lanes
    localparam int LANE_VX    = 0;
    localparam int LANE_VY    = 1;
    localparam int LANE_SPEED = 2;
    localparam int LANE_TURN  = 3;

    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032875;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    typedef logic [7:0] cfg_idx_t;
    localparam cfg_idx_t CFG_LEFT_MPC  = 8'd0;
    localparam cfg_idx_t CFG_RIGHT_MPC = 8'd1;
    localparam cfg_idx_t CFG_ANGLE_PM  = 8'd2;
    localparam cfg_idx_t CFG_TICKS_PS  = 8'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_L,
        OP_MUL_R,
        OP_SUM,
        OP_TH_LO,
        OP_TH_HI,
        OP_C_MID,
        OP_C_ITER,
        OP_C_FIN,
        OP_DX,
        OP_DY,
        OP_HEAD,
        OP_RV0,
        OP_RV1,
        OP_RV2,
        OP_RV3,
        OP_DSTART,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_SUM,
        S_TH_LO,
        S_TH_HI,
        S_C1_START,
        S_C1_ITER,
        S_C1_FIN,
        S_DX,
        S_DY,
        S_HEAD,
        S_RV0,
        S_RV1,
        S_RV2,
        S_RV3,
        S_DSTART,
        S_C2_ITER,
        S_C2_FIN,
        S_WAIT_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } odo_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } odo_status_t;

    // atan(2^-i) in binary-angle units
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/odo_div.sv @@
// ----------------------------------------------------------------------------
// odo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module odo_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [odo_pkg::DIV_NUM_W-1:0]  num,
    input  logic [odo_pkg::DIV_DEN_W-1:0]  den,
    output logic [odo_pkg::DIV_NUM_W-1:0]  quo,
    output logic                           done
);
    import odo_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den};
        ge        = (rem_sh >= {1'b0, den});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            quo_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign done = !busy_reg;

endmodule

@@ rtl/core/odo_datapath.sv @@
// ----------------------------------------------------------------------------
// odo_datapath
// Pose arithmetic: shared multiplier, CORDIC rotator, four divider lanes,
// configuration registers, pose state and the result register.
// ----------------------------------------------------------------------------
module odo_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  odo_pkg::odo_cmd_t     cmd,
    output odo_pkg::odo_status_t  status,
    input  logic                  cfg_we,
    input  odo_pkg::cfg_idx_t     cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic signed [31:0]    left_count,
    input  logic signed [31:0]    right_count,
    input  logic [23:0]           elapsed_ticks,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic [31:0]           heading,
    output logic signed [31:0]    vel_x,
    output logic signed [31:0]    vel_y,
    output logic signed [31:0]    speed,
    output logic signed [47:0]    turn_rate,
    output logic signed [31:0]    quat_z,
    output logic signed [31:0]    quat_w
);
    import odo_pkg::*;

    function automatic logic [31:0] sat32(input logic signed [DIV_NUM_W:0] v);
        logic [31:0] r;
        if (v > $signed((DIV_NUM_W+1)'(64'sd2147483647)))
            r = 32'h7fff_ffff;
        else if (v < -$signed((DIV_NUM_W+1)'(64'sd2147483648)))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [47:0] sat48(input logic signed [DIV_NUM_W:0] v);
        logic [47:0] r;
        if (v > $signed((DIV_NUM_W+1)'(64'sd140737488355327)))
            r = 48'h7fff_ffff_ffff;
        else if (v < -$signed((DIV_NUM_W+1)'(64'sd140737488355328)))
            r = 48'h8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

    // configuration and pose state
    logic [31:0] lmpc_reg, lmpc_next;
    logic [31:0] rmpc_reg, rmpc_next;
    logic [31:0] apm_reg, apm_next;
    logic [23:0] tps_reg, tps_next;
    logic [31:0] prev_l_reg, prev_l_next;
    logic [31:0] prev_r_reg, prev_r_next;
    logic [31:0] acc_x_reg, acc_x_next;
    logic [31:0] acc_y_reg, acc_y_next;
    logic [31:0] acc_h_reg, acc_h_next;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [31:0]        dcl_reg, dcl_next;
    logic [31:0]        dcr_reg, dcr_next;
    logic [23:0]        dt_reg, dt_next;
    logic signed [63:0] dl_reg, dl_next;
    logic signed [63:0] dr_reg, dr_next;
    logic signed [31:0] step_reg, step_next;
    logic [63:0]        diff_reg, diff_next;
    logic [31:0]        tlo_reg, tlo_next;
    logic [31:0]        dth_reg, dth_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [33:0] cz_reg, cz_next;
    logic               flip_reg, flip_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic [DIV_NUM_W-1:0] num_reg [NUM_LANES];
    logic [DIV_NUM_W-1:0] num_next [NUM_LANES];
    logic [NUM_LANES-1:0] neg_reg, neg_next;

    // result register
    logic [31:0] px_reg, px_next, py_reg, py_next, hd_reg, hd_next;
    logic [31:0] vx_reg, vx_next, vy_reg, vy_next, sp_reg, sp_next;
    logic [47:0] tr_reg, tr_next;
    logic [31:0] qz_reg, qz_next, qw_reg, qw_next;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [67:0] prod_mag;

    logic signed [63:0] sum;
    logic signed [63:0] sum_sh;
    logic [31:0]        ang_mid, head_new;
    logic [31:0]        ang_sel;
    logic [31:0]        ang_adj;
    logic signed [33:0] xs, ys, atan_ext, xf, yf;
    logic               div_start;
    logic [DIV_NUM_W-1:0] quo [NUM_LANES];
    logic [NUM_LANES-1:0] lane_done;
    logic signed [DIV_NUM_W:0] q_s [NUM_LANES];
    logic               dt_zero;
    logic               load_cordic;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_L:
            begin
                mul_a = 34'(signed'(dcl_reg));
                mul_b = $signed({2'b00, lmpc_reg});
            end
            OP_MUL_R:
            begin
                mul_a = 34'(signed'(dcr_reg));
                mul_b = $signed({2'b00, rmpc_reg});
            end
            OP_TH_LO:
            begin
                mul_a = $signed({2'b00, diff_reg[31:0]});
                mul_b = $signed({2'b00, apm_reg});
            end
            OP_TH_HI:
            begin
                mul_a = $signed({2'b00, diff_reg[63:32]});
                mul_b = $signed({2'b00, apm_reg});
            end
            OP_DX:
            begin
                mul_a = 34'(step_reg);
                mul_b = 34'(c_reg);
            end
            OP_DY:
            begin
                mul_a = 34'(step_reg);
                mul_b = 34'(s_reg);
            end
            OP_RV0:
            begin
                mul_a = 34'(dx_reg);
                mul_b = $signed({10'b0, tps_reg});
            end
            OP_RV1:
            begin
                mul_a = 34'(dy_reg);
                mul_b = $signed({10'b0, tps_reg});
            end
            OP_RV2:
            begin
                mul_a = 34'(step_reg);
                mul_b = $signed({10'b0, tps_reg});
            end
            OP_RV3:
            begin
                mul_a = 34'(signed'(dth_reg));
                mul_b = $signed({10'b0, tps_reg});
            end
            default:
            begin
            end
        endcase
        prod     = mul_a * mul_b;
        prod_mag = prod[67] ? -prod : prod;
    end

    always_comb
    begin
        sum      = (dl_reg >>> 1) + (dr_reg >>> 1);
        sum_sh   = sum >>> (32 - FRAC_BITS);
        ang_mid  = acc_h_reg + {dth_reg[31], dth_reg[31:1]};
        head_new = acc_h_reg + dth_reg;
        ang_sel  = (cmd.op == OP_HEAD) ? {1'b0, head_new[31:1]} : ang_mid;
        ang_adj  = {ang_sel[31] ^ (ang_sel[31] ^ ang_sel[30]), ang_sel[30:0]};
        xs       = cx_reg >>> cmd.iter;
        ys       = cy_reg >>> cmd.iter;
        atan_ext = $signed({2'b00, atan_turn(cmd.iter)});
        xf       = flip_reg ? -cx_reg : cx_reg;
        yf       = flip_reg ? -cy_reg : cy_reg;
        load_cordic = (cmd.op == OP_C_MID) || (cmd.op == OP_HEAD);
        div_start   = (cmd.op == OP_DSTART);
        dt_zero     = (dt_reg == '0);
    end

    always_comb
    begin
        lmpc_next      = lmpc_reg;
        rmpc_next      = rmpc_reg;
        apm_next       = apm_reg;
        tps_next       = tps_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_h_next     = acc_h_reg;
        out_valid_next = out_valid_reg && out_stall;
        dcl_next       = dcl_reg;
        dcr_next       = dcr_reg;
        dt_next        = dt_reg;
        dl_next        = dl_reg;
        dr_next        = dr_reg;
        step_next      = step_reg;
        diff_next      = diff_reg;
        tlo_next       = tlo_reg;
        dth_next       = dth_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hd_next        = hd_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        sp_next        = sp_reg;
        tr_next        = tr_reg;
        qz_next        = qz_reg;
        qw_next        = qw_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_MPC:  lmpc_next = cfg_data;
                CFG_RIGHT_MPC: rmpc_next = cfg_data;
                CFG_ANGLE_PM:  apm_next  = cfg_data;
                CFG_TICKS_PS:  tps_next  = cfg_data[23:0];
                default:
                begin
                end
            endcase
        end

        if (load_cordic)
        begin
            flip_next = ang_sel[31] ^ ang_sel[30];
            cx_next   = INV_GAIN_Q30;
            cy_next   = '0;
            cz_next   = 34'(signed'(flip_next ? {~ang_sel[31], ang_sel[30:0]} : ang_adj));
        end

        case (cmd.op)
            OP_LOAD:
            begin
                dcl_next    = left_count - prev_l_reg;
                dcr_next    = right_count - prev_r_reg;
                prev_l_next = left_count;
                prev_r_next = right_count;
                dt_next     = elapsed_ticks;
            end
            OP_MUL_L: dl_next = prod[63:0];
            OP_MUL_R: dr_next = prod[63:0];
            OP_SUM:
            begin
                if (sum_sh > 64'sd2147483647)
                    step_next = 32'sh7fff_ffff;
                else if (sum_sh < -64'sd2147483648)
                    step_next = 32'sh8000_0000;
                else
                    step_next = sum_sh[31:0];
                diff_next = dr_reg - dl_reg;
            end
            OP_TH_LO: tlo_next = prod[63:32];
            OP_TH_HI: dth_next = prod[31:0] + tlo_reg;
            OP_C_ITER:
            begin
                if (!cz_reg[33])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_ext;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_ext;
                end
            end
            OP_C_FIN:
            begin
                if (xf > ONE_Q30)
                    c_next = 32'(ONE_Q30);
                else if (xf < -ONE_Q30)
                    c_next = 32'(-ONE_Q30);
                else
                    c_next = xf[31:0];
                if (yf > ONE_Q30)
                    s_next = 32'(ONE_Q30);
                else if (yf < -ONE_Q30)
                    s_next = 32'(-ONE_Q30);
                else
                    s_next = yf[31:0];
            end
            OP_DX: dx_next = prod[62:30];
            OP_DY:
            begin
                dy_next    = prod[62:30];
                acc_x_next = acc_x_reg + dx_reg[31:0];
            end
            OP_HEAD:
            begin
                acc_y_next = acc_y_reg + dy_reg[31:0];
                acc_h_next = head_new;
            end
            OP_RV0:
            begin
                num_next[LANE_VX] = prod_mag[DIV_NUM_W-1:0];
                neg_next[LANE_VX] = prod[67];
            end
            OP_RV1:
            begin
                num_next[LANE_VY] = prod_mag[DIV_NUM_W-1:0];
                neg_next[LANE_VY] = prod[67];
            end
            OP_RV2:
            begin
                num_next[LANE_SPEED] = prod_mag[DIV_NUM_W-1:0];
                neg_next[LANE_SPEED] = prod[67];
            end
            OP_RV3:
            begin
                num_next[LANE_TURN] = prod_mag[DIV_NUM_W-1:0];
                neg_next[LANE_TURN] = prod[67];
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                px_next = acc_x_reg;
                py_next = acc_y_reg;
                hd_next = acc_h_reg;
                vx_next = dt_zero ? '0 : sat32(q_s[LANE_VX]);
                vy_next = dt_zero ? '0 : sat32(q_s[LANE_VY]);
                sp_next = dt_zero ? '0 : sat32(q_s[LANE_SPEED]);
                tr_next = dt_zero ? '0 : sat48(q_s[LANE_TURN]);
                qz_next = s_reg;
                qw_next = c_reg;
            end
            default:
            begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            odo_div u_div (
                .clk   (clk),
                .rst_n (rst_n),
                .start (div_start),
                .num   (num_reg[g]),
                .den   (dt_reg),
                .quo   (quo[g]),
                .done  (lane_done[g])
            );
            assign q_s[g] = neg_reg[g] ? -$signed({1'b0, quo[g]}) : $signed({1'b0, quo[g]});
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmpc_reg      <= 32'd571626;
            rmpc_reg      <= 32'd640219;
            apm_reg       <= 32'd1519034000;
            tps_reg       <= 24'd1000000;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lmpc_reg      <= lmpc_next;
            rmpc_reg      <= rmpc_next;
            apm_reg       <= apm_next;
            tps_reg       <= tps_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_h_reg     <= acc_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dcl_reg  <= dcl_next;
        dcr_reg  <= dcr_next;
        dt_reg   <= dt_next;
        dl_reg   <= dl_next;
        dr_reg   <= dr_next;
        step_reg <= step_next;
        diff_reg <= diff_next;
        tlo_reg  <= tlo_next;
        dth_reg  <= dth_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        flip_reg <= flip_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        hd_reg   <= hd_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        sp_reg   <= sp_next;
        tr_reg   <= tr_next;
        qz_reg   <= qz_next;
        qw_reg   <= qw_next;
    end

    assign status.div_done = &lane_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign heading   = hd_reg;
    assign vel_x     = vx_reg;
    assign vel_y     = vy_reg;
    assign speed     = sp_reg;
    assign turn_rate = tr_reg;
    assign quat_z    = qz_reg;
    assign quat_w    = qw_reg;

endmodule

@@ rtl/core/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer for one pose update: issues datapath operations in order and
// counts CORDIC iterations.
// ----------------------------------------------------------------------------
module odo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output odo_pkg::odo_cmd_t    cmd,
    input  odo_pkg::odo_status_t status
);
    import odo_pkg::*;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              cnt_last;

    assign cnt_last = (cnt_reg == ITER_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_MUL_L;
            S_MUL_L:    state_next = S_MUL_R;
            S_MUL_R:    state_next = S_SUM;
            S_SUM:      state_next = S_TH_LO;
            S_TH_LO:    state_next = S_TH_HI;
            S_TH_HI:    state_next = S_C1_START;
            S_C1_START:
            begin
                cnt_next   = '0;
                state_next = S_C1_ITER;
            end
            S_C1_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) state_next = S_C1_FIN;
            end
            S_C1_FIN:   state_next = S_DX;
            S_DX:       state_next = S_DY;
            S_DY:       state_next = S_HEAD;
            S_HEAD:     state_next = S_RV0;
            S_RV0:      state_next = S_RV1;
            S_RV1:      state_next = S_RV2;
            S_RV2:      state_next = S_RV3;
            S_RV3:      state_next = S_DSTART;
            S_DSTART:
            begin
                cnt_next   = '0;
                state_next = S_C2_ITER;
            end
            S_C2_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) state_next = S_C2_FIN;
            end
            S_C2_FIN:   state_next = S_WAIT_DIV;
            S_WAIT_DIV: if (status.div_done) state_next = S_OUT;
            S_OUT:      if (status.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.iter = cnt_reg;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
            S_MUL_L:    cmd.op = OP_MUL_L;
            S_MUL_R:    cmd.op = OP_MUL_R;
            S_SUM:      cmd.op = OP_SUM;
            S_TH_LO:    cmd.op = OP_TH_LO;
            S_TH_HI:    cmd.op = OP_TH_HI;
            S_C1_START: cmd.op = OP_C_MID;
            S_C1_ITER:  cmd.op = OP_C_ITER;
            S_C1_FIN:   cmd.op = OP_C_FIN;
            S_DX:       cmd.op = OP_DX;
            S_DY:       cmd.op = OP_DY;
            S_HEAD:     cmd.op = OP_HEAD;
            S_RV0:      cmd.op = OP_RV0;
            S_RV1:      cmd.op = OP_RV1;
            S_RV2:      cmd.op = OP_RV2;
            S_RV3:      cmd.op = OP_RV3;
            S_DSTART:   cmd.op = OP_DSTART;
            S_C2_ITER:  cmd.op = OP_C_ITER;
            S_C2_FIN:   cmd.op = OP_C_FIN;
            S_WAIT_DIV: cmd.op = OP_NONE;
            S_OUT:      if (status.out_free) cmd.op = OP_OUT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/core/diff_drive_odometry_unit.sv @@
// One transaction at a time: the input stalls from an accepted transaction
// until its result is written; the bit-serial velocity dividers set most of
// that time, output stalls add to it.
// A finished result waits in the output register while the next one is taken.
// Reset: asynchronous, active low; pose and previous counts cleared,
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit
// Differential-drive dead reckoning: wheel counts in, pose, velocities and
// heading quaternion out.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  left_count,
    input  logic signed [31:0]  right_count,
    input  logic [23:0]         elapsed_ticks,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [31:0]         heading,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y,
    output logic signed [31:0]  speed,
    output logic signed [47:0]  turn_rate,
    output logic signed [31:0]  quat_z,
    output logic signed [31:0]  quat_w,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  odo_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data
);
    import odo_pkg::*;

    odo_cmd_t    cmd;
    odo_status_t status;

    assign cfg_ready = 1'b1;

    odo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    odo_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left_count    (left_count),
        .right_count   (right_count),
        .elapsed_ticks (elapsed_ticks),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .speed         (speed),
        .turn_rate     (turn_rate),
        .quat_z        (quat_z),
        .quat_w        (quat_w)
    );

    // a transaction taken in starts the sequence, so the input stalls next
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // a new result only appears at the end of a busy sequence
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without preceding work");

    // CORDIC iterations only while the input side is stalled
    a_iter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_C_ITER) |-> in_stall)
        else $error("CORDIC step while idle");

endmodule
